[rtl/core/aabb_frustum_cull_test_unit_assert.svh]
// Assertion macros for the frustum cull test unit
`ifndef AABB_FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define AABB_FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH

// Implication check on the rising clock edge, off during reset
`define AFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check
`define AFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/afc_pkg.sv]
// Shared types and constants for the frustum cull test unit
package afc_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned SlotW = 3;

	// Input actions
	typedef enum logic [1:0] {
		ACT_PLANE = 2'd0,
		ACT_XFORM = 2'd1,
		ACT_TEST  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Width of each world-space coordinate register in the row
	localparam int unsigned WorldW = 2 * CoordW + 4;
	// Plane test sum width
	localparam int unsigned SumW = 3 * CoordW + 8;

	// Plane entry
	typedef struct packed {
		logic signed [CoordW-1:0] nx;
		logic signed [CoordW-1:0] ny;
		logic signed [CoordW-1:0] nz;
		logic signed [CoordW-1:0] off;
	} plane_t;

	// Row that travels down the plane cells: a box test or a plane load
	typedef struct packed {
		logic                     valid;
		logic                     pass;
		logic                     ld;
		logic [SlotW-1:0]         ld_slot;
		plane_t                   ld_plane;
		logic signed [WorldW-1:0] cx;
		logic signed [WorldW-1:0] cy;
		logic signed [WorldW-1:0] cz;
		logic        [WorldW-1:0] ex;
		logic        [WorldW-1:0] ey;
		logic        [WorldW-1:0] ez;
	} box_row_t;

	function automatic logic [CoordW:0] abs33(input logic signed [CoordW-1:0] v);
		logic signed [CoordW:0] w;
		w = {v[CoordW-1], v};
		return (v[CoordW-1]) ? 33'(-w) : 33'(w);
	endfunction

endpackage

[rtl/core/afc_xform.sv]
// Box transform front end: centre and world extent over two stages, plane loads ride along
module afc_xform (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          in_valid,
	input  logic                          in_pass,
	input  logic                          ld,
	input  logic [afc_pkg::SlotW-1:0]     ld_slot,
	input  afc_pkg::plane_t               ld_plane,
	input  logic signed [afc_pkg::CoordW-1:0] m [12],
	input  logic signed [afc_pkg::CoordW-1:0] c [3],
	input  logic signed [afc_pkg::CoordW-1:0] e [3],
	input  logic [4:0]                    frac_bits,
	output afc_pkg::box_row_t             row
);
	import afc_pkg::*;

	localparam int unsigned PW = 2 * CoordW;

	logic signed [PW-1:0] pc_s1 [9];
	logic        [PW-1:0] pe_s1 [9];
	logic signed [CoordW-1:0] t_s1 [3];
	logic valid_s1, pass_s1, ld_s1;
	logic [SlotW-1:0] ld_slot_s1;
	plane_t ld_plane_s1;
	logic [4:0] fb_s1;

	// Stage 1: nine centre products and nine extent products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ld_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			ld_s1 <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s1 <= in_pass;
			ld_slot_s1 <= ld_slot;
			ld_plane_s1 <= ld_plane;
			fb_s1 <= frac_bits;
			for (int i = 0; i < 3; i++) begin
				t_s1[i] <= m[9 + i];
				for (int j = 0; j < 3; j++) begin
					pc_s1[j*3+i] <= PW'(m[j*3+i] * c[j]);
					pe_s1[j*3+i] <= PW'(abs33(m[j*3+i]) * abs33(e[j]));
				end
			end
		end
	end

	// Stage 2: sums per axis
	logic signed [WorldW-1:0] cs [3];
	logic        [WorldW-1:0] es [3];
	box_row_t row_d;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cs[i] = (WorldW'(t_s1[i]) <<< fb_s1)
				+ WorldW'(pc_s1[i]) + WorldW'(pc_s1[3+i]) + WorldW'(pc_s1[6+i]);
			es[i] = WorldW'(pe_s1[i]) + WorldW'(pe_s1[3+i]) + WorldW'(pe_s1[6+i]);
		end
	end

	always_comb begin
		row_d = '0;
		row_d.valid = valid_s1;
		row_d.pass = pass_s1;
		row_d.ld = ld_s1;
		row_d.ld_slot = ld_slot_s1;
		row_d.ld_plane = ld_plane_s1;
		row_d.cx = cs[0];
		row_d.cy = cs[1];
		row_d.cz = cs[2];
		row_d.ex = es[0];
		row_d.ey = es[1];
		row_d.ez = es[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row <= '0;
		end else if (adv) begin
			row <= row_d;
		end
	end
endmodule

[rtl/core/afc_plane_cell.sv]
// One plane cell: holds its plane, tests the passing box against it, hands row on
module afc_plane_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      en,
	input  logic [afc_pkg::SlotW-1:0] slot_id,
	input  logic [4:0]                frac_bits,
	input  afc_pkg::box_row_t         row_in,
	output afc_pkg::box_row_t         row_out
);
	import afc_pkg::*;

	// Signed and unsigned partial product widths, half sum width
	localparam int unsigned PW = 2 * CoordW + 1;
	localparam int unsigned EW = 2 * CoordW;
	localparam int unsigned HW = 2 * CoordW + 4;

	plane_t plane_q;
	logic signed [WorldW-1:0] cv [3];
	logic        [WorldW-1:0] ev [3];
	logic signed [CoordW-1:0] nv [3];
	logic        [CoordW-1:0] na [3];
	logic signed [PW-1:0] pcl_s1 [3];
	logic signed [PW-1:0] pch_s1 [3];
	logic        [EW-1:0] pel_s1 [3];
	logic        [EW-1:0] peh_s1 [3];
	logic signed [SumW-1:0] off_s1;
	logic signed [HW-1:0] lo_sum;
	logic signed [HW-1:0] hi_sum;
	logic signed [HW-1:0] lo_s2;
	logic signed [HW-1:0] hi_s2;
	logic signed [SumW-1:0] off_s2;
	logic signed [SumW-1:0] sum;
	box_row_t row_s1, row_s2, row_c;

	// Plane register, loaded when its load item passes by
	always_ff @(posedge clk) begin
		if (adv && row_in.ld && row_in.ld_slot == slot_id) begin
			plane_q <= row_in.ld_plane;
		end
	end

	always_comb begin
		cv = '{row_in.cx, row_in.cy, row_in.cz};
		ev = '{row_in.ex, row_in.ey, row_in.ez};
		nv = '{plane_q.nx, plane_q.ny, plane_q.nz};
		for (int i = 0; i < 3; i++) begin
			na[i] = CoordW'(abs33(nv[i]));
		end
	end

	// Stage a: centre and extent split in 32-bit halves, twelve products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pcl_s1[i] <= PW'($signed({1'b0, cv[i][CoordW-1:0]}) * nv[i]);
				pch_s1[i] <= PW'($signed(cv[i][2*CoordW:CoordW]) * nv[i]);
				pel_s1[i] <= EW'(ev[i][CoordW-1:0] * na[i]);
				peh_s1[i] <= EW'(ev[i][2*CoordW-1:CoordW] * na[i]);
			end
			off_s1 <= (SumW'(plane_q.off) <<< {frac_bits, 1'b0});
		end
	end

	// Stage b: low and high half sums
	always_comb begin
		lo_sum = '0;
		hi_sum = '0;
		for (int i = 0; i < 3; i++) begin
			lo_sum = lo_sum + HW'(pcl_s1[i]) + $signed(HW'(pel_s1[i]));
			hi_sum = hi_sum + HW'(pch_s1[i]) + $signed(HW'(peh_s1[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s2 <= lo_sum;
			hi_s2 <= hi_sum;
			off_s2 <= off_s1;
		end
	end

	// Stage c: full signed sum and sign test
	always_comb begin
		sum = (SumW'(hi_s2) <<< CoordW) + SumW'(lo_s2) - off_s2;
		row_c = row_s2;
		row_c.pass = row_s2.pass & (!en | !sum[SumW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_s1 <= '0;
			row_s2 <= '0;
			row_out <= '0;
		end else if (adv) begin
			row_s1 <= row_in;
			row_s2 <= row_s1;
			row_out <= row_c;
		end
	end
endmodule

[rtl/core/aabb_frustum_cull_test_unit.sv]
// Top level of the frustum cull test unit
// One item is taken every cycle unless in_stall is high. Transform loads
// write their registers at the transfer; plane loads travel down the row
// with the boxes and are taken by their cell, so every item sees all loads
// before it, even back to back. Loads yield no result. A box test runs
// through two transform stages and then a row of NUM_PLANES plane cells,
// three stages each. The whole row moves together and halts only when the
// output register is full and stalled. Configure cull_enable only when idle.
module aabb_frustum_cull_test_unit #(
	parameter int NUM_PLANES = 6,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [2:0]  slot,
	input  logic signed [31:0] vec_a_x,
	input  logic signed [31:0] vec_a_y,
	input  logic signed [31:0] vec_a_z,
	input  logic signed [31:0] vec_b_x,
	input  logic signed [31:0] vec_b_y,
	input  logic signed [31:0] vec_b_z,
	input  logic signed [31:0] plane_offset,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        visible
);
	import afc_pkg::*;
	`include "aabb_frustum_cull_test_unit_assert.svh"

	localparam logic [4:0] Fb = 5'(FRAC_BITS);

	logic cull_en_q;
	logic signed [CoordW-1:0] xf_q [12];
	logic [3:0] xf_base;
	plane_t ld_plane;
	logic adv, in_xfer;
	action_t act;

	assign act = action_t'(action);
	// Pipeline advances unless a result waits and is stalled
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign in_xfer = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cull_en_q <= 1'b1;
		end else if (cfg_we) begin
			cull_en_q <= cfg_wdata;
		end
	end

	// Transform loads
	assign xf_base = 4'(slot[1:0]) * 4'd3;
	always_ff @(posedge clk) begin
		if (in_xfer && act == ACT_XFORM && slot <= 3'd3) begin
			xf_q[xf_base] <= vec_a_x;
			xf_q[xf_base + 4'd1] <= vec_a_y;
			xf_q[xf_base + 4'd2] <= vec_a_z;
		end
	end

	logic signed [CoordW-1:0] c [3];
	logic signed [CoordW-1:0] e [3];
	assign c = '{vec_a_x, vec_a_y, vec_a_z};
	assign e = '{vec_b_x, vec_b_y, vec_b_z};
	assign ld_plane = '{vec_a_x, vec_a_y, vec_a_z, plane_offset};

	box_row_t rows [NUM_PLANES+1];

	afc_xform u_xform (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_valid(in_xfer && act == ACT_TEST), .in_pass(1'b1),
		.ld(in_xfer && act == ACT_PLANE), .ld_slot(slot), .ld_plane(ld_plane),
		.m(xf_q), .c(c), .e(e), .frac_bits(Fb), .row(rows[0])
	);

	// Row of plane cells
	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
		afc_plane_cell u_cell (
			.clk(clk), .arst_n(arst_n), .adv(adv), .en(cull_en_q),
			.slot_id(SlotW'(p)), .frac_bits(Fb),
			.row_in(rows[p]), .row_out(rows[p+1])
		);
	end

	assign out_valid = rows[NUM_PLANES].valid;
	assign visible = rows[NUM_PLANES].pass;

	`AFC_ASSERT_IMP(a_stall_when_held, clk, arst_n, out_valid && out_stall, in_stall, "input not stalled while result held")
	`AFC_ASSERT_NEXT(a_hold_result, clk, arst_n, out_valid && out_stall, out_valid && $stable(visible), "held result changed")
	`AFC_ASSERT_IMP(a_off_visible, clk, arst_n, out_valid && !cull_en_q && $stable(cull_en_q), visible, "cull disabled check")
endmodule
